// ===== rtl/core/a85e_pkg.sv =====
// ============================================================================
// a85e_pkg
// Shared types and constants for the Ascii85 encoder.
// ============================================================================
`default_nettype none

package a85e_pkg;

  localparam int unsigned A85E_QUEUE_DEPTH = 2;
  localparam int unsigned A85E_ADDR_W      = 3;

  localparam logic A85E_IDX_ADOBE = 1'b0;

  // floor(2^38 / 85): quotient estimate is exact or one low
  localparam logic [31:0] A85E_RECIP       = 32'd3233857728;
  localparam int unsigned A85E_RECIP_SHIFT = 38;
  localparam logic [7:0]  A85E_BASE        = 8'd85;
  localparam logic [6:0]  A85E_OFFSET      = 7'h21;

  localparam logic [6:0] A85E_CH_Z     = 7'h7A;
  localparam logic [6:0] A85E_CH_LT    = 7'h3C;
  localparam logic [6:0] A85E_CH_GT    = 7'h3E;
  localparam logic [6:0] A85E_CH_TILDE = 7'h7E;

  localparam logic [2:0] A85E_FULL_DIGITS = 3'd5;

  typedef struct packed {
    logic        opener;
    logic        zero;
    logic        closer;
    logic        last;
    logic [2:0]  ndig;
    logic [31:0] word;
  } fj_t;

  typedef struct packed {
    logic            opener;
    logic            zero;
    logic            closer;
    logic            last;
    logic [2:0]      ndig;
    logic [4:0][6:0] digits;
  } ej_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_MUL,
    CV_FIX,
    CV_OUT
  } cv_state_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_OPEN0,
    EM_OPEN1,
    EM_BODY,
    EM_CLOSE0,
    EM_CLOSE1
  } em_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/a85e_if.sv =====
// ============================================================================
// a85e_if
// Byte and character channels of the Ascii85 encoder.
// ============================================================================
`default_nettype none

interface a85e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface a85e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_end;
  logic       message_done;

  modport source (output valid, output out_char, output run_end, output message_done,
                  input ready);
  modport sink   (input valid, input out_char, input run_end, input message_done,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/a85e_front.sv =====
// ============================================================================
// a85e_front
// Gathers bytes into big-endian groups and classifies each beat into a job.
// ============================================================================
`default_nettype none

module a85e_front (
  input  logic               clk,
  input  logic               rst_n,
  a85e_byte_if.sink          in_ch,
  input  logic               adobe_i,
  output a85e_pkg::fj_t      job_o,
  output logic               job_valid_o,
  input  logic               job_ready_i
);
  import a85e_pkg::*;

  logic [23:0] group_r, group_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        inside_r, inside_nxt;
  logic [31:0] word;
  logic        full;
  logic        last;
  logic        acc;

  always_comb begin
    case (pos_r)
      2'd0:    word = {in_ch.data_byte, 24'h0};
      2'd1:    word = {group_r[23:16], in_ch.data_byte, 16'h0};
      2'd2:    word = {group_r[23:8], in_ch.data_byte, 8'h0};
      default: word = {group_r, in_ch.data_byte};
    endcase
  end

  assign full = (pos_r == 2'd3);
  assign last = in_ch.message_end;
  assign acc  = in_ch.valid & in_ch.ready;

  assign in_ch.ready = job_ready_i;

  always_comb begin
    job_o.opener = ~inside_r & adobe_i;
    job_o.zero   = full & (word == 32'h0);
    job_o.closer = last & adobe_i;
    job_o.last   = last;
    job_o.word   = word;
    if (full) begin
      job_o.ndig = (word == 32'h0) ? 3'd0 : A85E_FULL_DIGITS;
    end else if (last) begin
      job_o.ndig = {1'b0, pos_r} + 3'd2;
    end else begin
      job_o.ndig = 3'd0;
    end
  end

  assign job_valid_o = in_ch.valid & (job_o.opener | full | last);

  always_comb begin
    group_nxt  = group_r;
    pos_nxt    = pos_r;
    inside_nxt = inside_r;
    if (acc) begin
      inside_nxt = ~last;
      if (full | last) begin
        group_nxt = 24'h0;
        pos_nxt   = 2'd0;
      end else begin
        group_nxt = word[31:8];
        pos_nxt   = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r  <= 24'h0;
      pos_r    <= 2'd0;
      inside_r <= 1'b0;
    end else begin
      group_r  <= group_nxt;
      pos_r    <= pos_nxt;
      inside_r <= inside_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/a85e_queue.sv =====
// ============================================================================
// a85e_queue
// Short job queue between the front and the digit converter.
// ============================================================================
`default_nettype none

module a85e_queue #(
  parameter int unsigned DEPTH = a85e_pkg::A85E_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  a85e_pkg::fj_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output a85e_pkg::fj_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import a85e_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fj_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  assign push_ready_o = (cnt_r != CW'(DEPTH));
  assign pop_valid_o  = (cnt_r != '0);
  assign pop_data_o   = mem_r[rd_r];

  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push & ~pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop & ~push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/a85e_conv.sv =====
// ============================================================================
// a85e_conv
// Base-85 digit converter: four divisions by 85 through one reciprocal
// multiplier, each a multiply step and a fix-up step.
// ============================================================================
`default_nettype none

module a85e_conv (
  input  logic          clk,
  input  logic          rst_n,
  input  a85e_pkg::fj_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  output a85e_pkg::ej_t ej_o,
  output logic          ej_valid_o,
  input  logic          ej_ready_i
);
  import a85e_pkg::*;

  cv_state_t       state_r, state_nxt;
  fj_t             job_r;
  logic [31:0]     v_r;
  logic [25:0]     q0_r;
  logic [1:0]      step_r;
  logic [4:0][6:0] dig_r;

  logic        load;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [32:0] q85;
  logic [32:0] rem_full;
  logic [7:0]  rem;
  logic        fix;
  logic [25:0] q;
  logic [6:0]  digit;
  logic [2:0]  dig_idx;

  // outputs
  always_comb begin
    load        = job_valid_i & ((state_r == CV_IDLE) | ((state_r == CV_OUT) & ej_ready_i));
    job_ready_o = load;
    ej_valid_o  = (state_r == CV_OUT);
  end

  // next state
  always_comb begin
    case (state_r)
      CV_IDLE: begin
        if (load) begin
          state_nxt = (job_i.ndig != 3'd0) ? CV_FIX : CV_OUT;
        end else begin
          state_nxt = CV_IDLE;
        end
      end
      CV_MUL:  state_nxt = CV_FIX;
      CV_FIX:  state_nxt = (step_r == 2'd3) ? CV_OUT : CV_MUL;
      CV_OUT: begin
        if (load) begin
          state_nxt = (job_i.ndig != 3'd0) ? CV_FIX : CV_OUT;
        end else if (ej_ready_i) begin
          state_nxt = CV_IDLE;
        end else begin
          state_nxt = CV_OUT;
        end
      end
      default: state_nxt = CV_IDLE;
    endcase
  end

  assign mul_a = (state_r == CV_MUL) ? v_r : job_i.word;
  assign prod  = 64'(mul_a) * 64'(A85E_RECIP);

  assign q85      = {7'b0, q0_r} * 33'(A85E_BASE);
  assign rem_full = {1'b0, v_r} - q85;
  assign rem      = rem_full[7:0];
  assign fix      = (rem >= A85E_BASE);
  assign q        = fix ? q0_r + 26'd1 : q0_r;
  assign digit    = fix ? 7'(rem - A85E_BASE) : rem[6:0];
  assign dig_idx  = 3'd4 - {1'b0, step_r};

  always_ff @(posedge clk) begin
    if (load || state_r == CV_MUL) begin
      q0_r <= prod[63:A85E_RECIP_SHIFT];
    end
    if (load) begin
      job_r  <= job_i;
      v_r    <= job_i.word;
      step_r <= 2'd0;
    end else if (state_r == CV_FIX) begin
      dig_r[dig_idx] <= digit;
      v_r            <= {6'b0, q};
      step_r         <= step_r + 2'd1;
      if (step_r == 2'd3) begin
        dig_r[0] <= q[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ej_o.opener = job_r.opener;
    ej_o.zero   = job_r.zero;
    ej_o.closer = job_r.closer;
    ej_o.last   = job_r.last;
    ej_o.ndig   = job_r.ndig;
    ej_o.digits = dig_r;
  end

endmodule

`default_nettype wire

// ===== rtl/core/a85e_emit.sv =====
// ============================================================================
// a85e_emit
// Character sequencer: delimiters, 'z' or digits, one beat per cycle while
// the receiver is ready, through a registered output.
// ============================================================================
`default_nettype none

module a85e_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  a85e_pkg::ej_t ej_i,
  input  logic          ej_valid_i,
  output logic          ej_ready_o,
  a85e_char_if.source   out_ch
);
  import a85e_pkg::*;

  em_state_t  state_r, state_nxt, after_s, first_s;
  ej_t        job_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  logic [6:0] oc_r;
  logic       ore_r;
  logic       omd_r;

  logic       take;
  logic       advance;
  logic       body_end;
  logic [6:0] ch;

  // outputs
  always_comb begin
    ej_ready_o = (state_r == EM_IDLE);
    take       = ej_valid_i & ej_ready_o;
    advance    = (state_r != EM_IDLE) & (~ov_r | out_ch.ready);
    body_end   = job_r.zero | (cnt_r == job_r.ndig - 3'd1);
    case (state_r)
      EM_OPEN0:  ch = A85E_CH_LT;
      EM_OPEN1:  ch = A85E_CH_TILDE;
      EM_BODY:   ch = job_r.zero ? A85E_CH_Z : job_r.digits[cnt_r] + A85E_OFFSET;
      EM_CLOSE0: ch = A85E_CH_TILDE;
      EM_CLOSE1: ch = A85E_CH_GT;
      default:   ch = A85E_CH_Z;
    endcase
  end

  // next state
  always_comb begin
    if (ej_i.opener) begin
      first_s = EM_OPEN0;
    end else if (ej_i.zero | (ej_i.ndig != 3'd0)) begin
      first_s = EM_BODY;
    end else begin
      first_s = EM_CLOSE0;
    end

    case (state_r)
      EM_OPEN0:  after_s = EM_OPEN1;
      EM_OPEN1: begin
        if (job_r.zero | (job_r.ndig != 3'd0)) begin
          after_s = EM_BODY;
        end else begin
          after_s = job_r.closer ? EM_CLOSE0 : EM_IDLE;
        end
      end
      EM_BODY: begin
        if (body_end) begin
          after_s = job_r.closer ? EM_CLOSE0 : EM_IDLE;
        end else begin
          after_s = EM_BODY;
        end
      end
      EM_CLOSE0: after_s = EM_CLOSE1;
      EM_CLOSE1: after_s = EM_IDLE;
      default:   after_s = EM_IDLE;
    endcase

    if (take) begin
      state_nxt = first_s;
    end else if (advance) begin
      state_nxt = after_s;
    end else begin
      state_nxt = state_r;
    end

    if (take) begin
      cnt_nxt = 3'd0;
    end else if (advance && state_r == EM_BODY) begin
      cnt_nxt = cnt_r + 3'd1;
    end else begin
      cnt_nxt = cnt_r;
    end

    if (advance) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= ej_i;
    end
    if (advance) begin
      oc_r  <= ch;
      ore_r <= (after_s == EM_IDLE);
      omd_r <= (after_s == EM_IDLE) & job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      cnt_r   <= 3'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.out_char     = oc_r;
  assign out_ch.run_end      = ore_r;
  assign out_ch.message_done = omd_r;

endmodule

`default_nettype wire

// ===== rtl/core/ascii85_encoder.sv =====
// ============================================================================
// ascii85_encoder
// Streaming Ascii85 encoder with optional <~ ~> framing, APB control.
// ============================================================================
// Bytes are taken one per cycle, while the job queue of QUEUE_DEPTH entries
// has room; a byte that completes no group, opens no frame and ends no
// message gives no job. Each four-byte group needs four divisions by 85 on
// the shared reciprocal multiplier of the digit converter, with the first
// multiply overlapping the hand-over; an all-zero group skips the divisions.
// The character sequencer takes a new job only while idle and emits each
// delimiter as a character of its own. Characters leave one beat per cycle
// from a registered output while the receiver is ready. Register 0 at byte
// address 0 (bit 0) enables framing; it is sampled on the first and the
// last byte of each message.
`default_nettype none

module ascii85_encoder #(
  parameter int unsigned QUEUE_DEPTH = a85e_pkg::A85E_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  a85e_byte_if.sink                        in_ch,
  a85e_char_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [a85e_pkg::A85E_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import a85e_pkg::*;

  logic adobe_r, adobe_nxt;
  logic cfg_wr;

  fj_t  fq_data, qc_data;
  logic fq_valid, fq_ready, qc_valid, qc_ready;
  ej_t  ce_data;
  logic ce_valid, ce_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == A85E_IDX_ADOBE);
  assign prdata = (paddr[2] == A85E_IDX_ADOBE) ? {31'b0, adobe_r} : 32'h0;

  always_comb begin
    adobe_nxt = cfg_wr ? pwdata[0] : adobe_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adobe_r <= 1'b0;
    end else begin
      adobe_r <= adobe_nxt;
    end
  end

  a85e_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .adobe_i     (adobe_r),
    .job_o       (fq_data),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready)
  );

  a85e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_data_i  (fq_data),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .pop_data_o   (qc_data),
    .pop_valid_o  (qc_valid),
    .pop_ready_i  (qc_ready)
  );

  a85e_conv u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_i       (qc_data),
    .job_valid_i (qc_valid),
    .job_ready_o (qc_ready),
    .ej_o        (ce_data),
    .ej_valid_o  (ce_valid),
    .ej_ready_i  (ce_ready)
  );

  a85e_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ej_i       (ce_data),
    .ej_valid_i (ce_valid),
    .ej_ready_o (ce_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/sv/a85e_stream_checker.sv =====
// ============================================================================
// a85e_stream_checker
// Watches the byte, character and register ports of the Ascii85 encoder,
// keeps its own copy of the grouping state and the framing bit, works out
// the characters each accepted byte must produce and compares every
// character beat against the oldest one still owed.
// ============================================================================

module a85e_stream_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  a85e_byte_if                             in_mon,
  a85e_char_if                             out_mon,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [a85e_pkg::A85E_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output int                               fault_count,
  output int                               chars_owed
);
  import a85e_pkg::*;

  typedef struct packed {
    logic [6:0] code;
    logic       run_end;
    logic       message_done;
  } char_beat_t;

  char_beat_t  owed_chars [$];
  logic [31:0] group_acc;
  int unsigned group_fill;
  logic        in_message;
  logic        framing_on;
  int          faults = 0;

  // digit 0 is the least significant
  function automatic logic [4:0][6:0] base85_digits(input logic [31:0] word);
    logic [4:0][6:0] d;
    logic [31:0]     v;
    v = word;
    for (int i = 0; i < 5; i++) begin
      d[i] = 7'(v % 32'd85) + A85E_OFFSET;
      v    = v / 32'd85;
    end
    return d;
  endfunction

  task automatic encode_byte(input logic [7:0] data, input logic last);
    logic [6:0]      chars [$];
    logic [4:0][6:0] digits;
    char_beat_t      beat;
    if (!in_message && framing_on) begin
      chars = {chars, A85E_CH_LT};
      chars = {chars, A85E_CH_TILDE};
    end
    in_message = 1'b1;
    group_acc  = group_acc | (32'(data) << (24 - 8 * group_fill));
    group_fill++;
    if (group_fill == 4) begin
      if (group_acc == 32'd0) begin
        chars = {chars, A85E_CH_Z};
      end else begin
        digits = base85_digits(group_acc);
        for (int i = 4; i >= 0; i--) chars = {chars, digits[i]};
      end
      group_acc  = '0;
      group_fill = 0;
    end
    if (last) begin
      // partial tail: k bytes give k+1 digits, never 'z'
      if (group_fill > 0) begin
        digits = base85_digits(group_acc);
        for (int i = 0; i <= int'(group_fill); i++) chars = {chars, digits[4 - i]};
      end
      if (framing_on) begin
        chars = {chars, A85E_CH_TILDE};
        chars = {chars, A85E_CH_GT};
      end
      group_acc  = '0;
      group_fill = 0;
      in_message = 1'b0;
    end
    foreach (chars[i]) begin
      beat.code         = chars[i];
      beat.run_end      = (i == chars.size() - 1);
      beat.message_done = last && (i == chars.size() - 1);
      owed_chars = {owed_chars, beat};
    end
  endtask

  task automatic check_char();
    char_beat_t want;
    if (owed_chars.size() == 0) begin
      $error("unexpected beat: out_char %0h", out_mon.out_char);
      faults++;
    end else begin
      want = owed_chars.pop_front();
      if (out_mon.out_char !== want.code) begin
        $error("out_char: expected %0h, got %0h", want.code, out_mon.out_char);
        faults++;
      end
      if (out_mon.run_end !== want.run_end) begin
        $error("run_end: expected %0b, got %0b", want.run_end, out_mon.run_end);
        faults++;
      end
      if (out_mon.message_done !== want.message_done) begin
        $error("message_done: expected %0b, got %0b", want.message_done,
               out_mon.message_done);
        faults++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_chars.delete();
      group_acc  = '0;
      group_fill = 0;
      in_message = 1'b0;
      framing_on = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[A85E_ADDR_W-1:2] == A85E_IDX_ADOBE) begin
        framing_on = pwdata[0];
      end
      if (in_mon.valid && in_mon.ready) encode_byte(in_mon.data_byte, in_mon.message_end);
      if (out_mon.valid && out_mon.ready) check_char();
    end
    fault_count <= faults;
    chars_owed  <= owed_chars.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ============================================================================
// testbench
// Stimulus and verdict for the Ascii85 encoder: a short directed set of
// messages covering zero groups, partial tails and framing changes inside a
// message, then three random phases with shifting sender and receiver
// idling, one of them with a long receiver hold-off to back the block up.
// ============================================================================

module testbench;
  import a85e_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 115;

  localparam logic [A85E_ADDR_W-1:0] ADOBE_ADDR    = A85E_ADDR_W'(A85E_IDX_ADOBE) << 2;
  localparam logic [A85E_ADDR_W-1:0] UNMAPPED_ADDR = A85E_ADDR_W'(A85E_IDX_ADOBE + 1) << 2;
  localparam logic [31:0]            FRAMING_OFF   = 32'd0;
  localparam logic [31:0]            FRAMING_ON    = 32'd1;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [A85E_ADDR_W-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  int         src_gap_pct  = 24;
  int         sink_gap_pct = 86;
  bit         hold_request = 1'b0;
  int         chk_faults;
  int         chk_owed;
  logic [7:0] msg_buf [$];

  a85e_byte_if in_ch();
  a85e_char_if out_ch();

  ascii85_encoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  a85e_stream_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fault_count (chk_faults),
    .chars_owed  (chk_owed)
  );

  always #5 clk = ~clk;

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.message_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_msg_buf(input logic end_flag);
    foreach (msg_buf[i]) send_byte(msg_buf[i], end_flag && (i == msg_buf.size() - 1));
  endtask

  task automatic send_random_message(output int len);
    int style;
    len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    style = $urandom_range(9);
    msg_buf.delete();
    for (int i = 0; i < len; i++) begin
      case (style)
        0, 1:    msg_buf = {msg_buf, 8'h00};
        2:       msg_buf = {msg_buf, 8'hFF};
        default: msg_buf = {msg_buf,
                            ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(255))};
      endcase
    end
    send_msg_buf(1'b1);
  endtask

  task automatic reg_write(input logic [A85E_ADDR_W-1:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // all owed characters out, then room for bytes that give none
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_owed != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int target, input int hold_at);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_request = 1'b1;
        hold_at      = -1;
      end
      send_random_message(len);
      sent += len;
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.message_end <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unmapped register: framing must stay off
    reg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    reg_write(ADOBE_ADDR, FRAMING_OFF);
    msg_buf = '{8'h00};
    send_msg_buf(1'b1);
    msg_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_msg_buf(1'b1);
    msg_buf = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h12};
    send_msg_buf(1'b1);
    wait_idle();

    reg_write(ADOBE_ADDR, FRAMING_ON);
    msg_buf = '{8'hFF};
    send_msg_buf(1'b1);
    msg_buf = '{8'h80, 8'h01};
    send_msg_buf(1'b1);
    msg_buf = '{8'hAB, 8'hCD, 8'hEF};
    send_msg_buf(1'b1);
    // framing dropped mid-message: opener, no closer
    msg_buf = '{8'h01, 8'h02};
    send_msg_buf(1'b0);
    wait_idle();
    reg_write(ADOBE_ADDR, FRAMING_OFF);
    msg_buf = '{8'h03};
    send_msg_buf(1'b1);
    // framing raised mid-message: closer, no opener
    msg_buf = '{8'h55};
    send_msg_buf(1'b0);
    wait_idle();
    reg_write(ADOBE_ADDR, FRAMING_ON);
    msg_buf = '{8'h66, 8'h77, 8'h88};
    send_msg_buf(1'b1);
    wait_idle();

    run_phase(PHASE_ITEMS, -1);
    wait_idle();

    reg_write(ADOBE_ADDR, FRAMING_OFF);
    src_gap_pct  = 86;
    sink_gap_pct = 24;
    run_phase(PHASE_ITEMS, -1);
    wait_idle();

    reg_write(ADOBE_ADDR, FRAMING_ON);
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    run_phase(PHASE_ITEMS, 30);
    wait_idle();

    if (chk_faults == 0 && chk_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
